>>> hdl/fbe_pkg.sv
// fbe_pkg: shared types, action codes and constants for the function block evaluator
// used by fbe_ctrl, fbe_datapath and function_block_evaluator_unit
package fbe_pkg;

    localparam int NODE_COUNT  = 256;
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int MAX_SOURCES = 8;
    localparam int SRC_W       = $clog2(MAX_SOURCES);
    localparam int VALUE_W     = 32;
    localparam logic [VALUE_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        ACT_LAND    = 4'd0,
        ACT_LOR     = 4'd1,
        ACT_LNOT    = 4'd2,
        ACT_LXOR    = 4'd3,
        ACT_ADD     = 4'd4,
        ACT_SUB     = 4'd5,
        ACT_MUL     = 4'd6,
        ACT_DIV     = 4'd7,
        ACT_BAND    = 4'd8,
        ACT_BOR     = 4'd9,
        ACT_SHL     = 4'd10,
        ACT_SHR     = 4'd11,
        ACT_LOAD    = 4'd12,
        ACT_SETHOLD = 4'd13
    } action_t;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_BOOL = 2'd1;
    localparam logic [1:0] KIND_NUM  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RDDST,
        ST_RDSRC,
        ST_ACC,
        ST_MULW,
        ST_DIV,
        ST_WRITE,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic              load_item;
        logic              clear_wr;
        logic [NODE_W-1:0] clear_addr;
        logic              rd_dst;
        logic              rd_src;
        logic [SRC_W-1:0]  src_sel;
        logic              acc_first;
        logic              acc_step;
        logic              mul_fin;
        logic              div_start;
        logic              div_step;
        logic              commit;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [3:0]       action;
        logic [SRC_W:0]   count;
        logic             div_done;
    } dp_stat_t;

endpackage

>>> hdl/fbe_datapath.sv
// fbe_datapath: node stores, source reduction unit, multiplier and serial divider
// depends on fbe_pkg
module fbe_datapath
    import fbe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [111:0]        in_data,
    output logic [47:0]         out_data
);

    logic [VALUE_W-1:0] val_mem [NODE_COUNT];
    logic [1:0]         kind_mem [NODE_COUNT];
    logic               hold_mem [NODE_COUNT];

    logic [3:0]         act_reg;
    logic [NODE_W-1:0]  dst_reg;
    logic [SRC_W:0]     cnt_reg;
    logic [NODE_W-1:0]  src_reg [MAX_SOURCES];
    logic [VALUE_W-1:0] opnd_reg;

    logic [VALUE_W-1:0] dval_reg, rd_reg, acc_reg, opb_reg, prod_reg;
    logic [1:0]         dkind_reg;
    logic               dhold_reg;
    logic [VALUE_W-1:0] quo_reg, rem_reg;
    logic [5:0]         dcnt_reg;
    logic [VALUE_W-1:0] res_val;
    logic [1:0]         res_kind;
    logic               res_hold, res_dz;
    logic [VALUE_W-1:0] ov_reg;
    logic [1:0]         ok_reg;
    logic               odz_reg;
    logic [NODE_W-1:0]  oidx_reg;
    logic [3:0]         raw_cnt;
    logic [VALUE_W:0]   rem_sh;

    assign raw_cnt = in_data[15:12];

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            act_reg <= in_data[3:0];
            dst_reg <= in_data[11:4];
            if (raw_cnt == 4'd0)
                cnt_reg <= (SRC_W+1)'(1);
            else if (raw_cnt > 4'(MAX_SOURCES))
                cnt_reg <= (SRC_W+1)'(MAX_SOURCES);
            else
                cnt_reg <= raw_cnt[SRC_W:0];
            for (int k = 0; k < MAX_SOURCES; k++)
                src_reg[k] <= in_data[16+8*k +: 8];
            opnd_reg <= in_data[80 +: 32];
        end
    end

    // one write and up to two registered reads per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            val_mem[cmd.clear_addr]  <= '0;
            kind_mem[cmd.clear_addr] <= KIND_NONE;
            hold_mem[cmd.clear_addr] <= 1'b0;
        end
        else if (cmd.commit)
        begin
            val_mem[dst_reg]  <= res_val;
            kind_mem[dst_reg] <= res_kind;
            hold_mem[dst_reg] <= res_hold;
        end
        if (cmd.rd_dst)
        begin
            dval_reg  <= val_mem[dst_reg];
            dkind_reg <= kind_mem[dst_reg];
            dhold_reg <= hold_mem[dst_reg];
        end
        if (cmd.rd_src)
            rd_reg <= val_mem[src_reg[cmd.src_sel]];
    end

    // reduction accumulator, one source per step
    always_ff @(posedge clk)
    begin
        if (cmd.acc_first)
            acc_reg <= rd_reg;
        else if (cmd.acc_step)
        begin
            opb_reg <= rd_reg;
            case (action_t'(act_reg))
                ACT_LAND: acc_reg <= {31'd0, (acc_reg != '0) && (rd_reg != '0)};
                ACT_LOR:  acc_reg <= {31'd0, (acc_reg != '0) || (rd_reg != '0)};
                ACT_LXOR: acc_reg <= acc_reg ^ rd_reg;
                ACT_ADD:  acc_reg <= acc_reg + rd_reg;
                ACT_BAND: acc_reg <= acc_reg & rd_reg;
                ACT_BOR:  acc_reg <= acc_reg | rd_reg;
                ACT_MUL:  prod_reg <= 32'(acc_reg * rd_reg);
                default:  acc_reg <= acc_reg;
            endcase
        end
        else if (cmd.mul_fin)
            acc_reg <= prod_reg;
    end

    // restoring divider, one quotient bit per cycle; acc holds dividend, opb divisor
    assign rem_sh = {rem_reg, quo_reg[VALUE_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.div_start)
            dcnt_reg <= 6'd32;
        else if (cmd.div_step && dcnt_reg != 6'd0)
            dcnt_reg <= dcnt_reg - 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= acc_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step && dcnt_reg != 6'd0)
        begin
            if (rem_sh >= {1'b0, opb_reg})
            begin
                rem_reg <= 32'(rem_sh - {1'b0, opb_reg});
                quo_reg <= {quo_reg[VALUE_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[VALUE_W-1:0];
                quo_reg <= {quo_reg[VALUE_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        res_val  = dval_reg;
        res_kind = dkind_reg;
        res_hold = dhold_reg;
        res_dz   = 1'b0;
        case (action_t'(act_reg))
            ACT_LAND, ACT_LOR, ACT_LXOR:
            begin
                res_val  = ((dhold_reg ? dval_reg : acc_reg) != '0) ? ALL_ONES : '0;
                res_kind = KIND_BOOL;
            end
            ACT_LNOT:
            begin
                if (!dhold_reg)
                    res_val = (acc_reg != '0) ? '0 : ALL_ONES;
                res_kind = KIND_BOOL;
            end
            ACT_ADD:
            begin
                if (!dhold_reg)
                begin
                    res_val  = acc_reg;
                    res_kind = KIND_NUM;
                end
            end
            ACT_BAND, ACT_BOR:
            begin
                if (!dhold_reg)
                    res_val = acc_reg;
                res_kind = KIND_NUM;
            end
            ACT_MUL:
            begin
                res_val  = acc_reg;
                res_kind = KIND_NUM;
            end
            ACT_SUB:
            begin
                res_val  = acc_reg - opb_reg;
                res_kind = KIND_NUM;
            end
            ACT_DIV:
            begin
                res_dz   = (opb_reg == '0);
                res_val  = res_dz ? '0 : quo_reg;
                res_kind = KIND_NUM;
            end
            ACT_SHL:
            begin
                res_val  = (opnd_reg >= 32'd32) ? '0 : (acc_reg << opnd_reg[4:0]);
                res_kind = KIND_NUM;
            end
            ACT_SHR:
            begin
                res_val  = (opnd_reg >= 32'd32) ? '0 : (acc_reg >> opnd_reg[4:0]);
                res_kind = KIND_NUM;
            end
            ACT_LOAD:    res_val  = opnd_reg;
            ACT_SETHOLD: res_hold = opnd_reg[0];
            default:     res_val  = dval_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            oidx_reg <= dst_reg;
            ov_reg   <= res_val;
            ok_reg   <= res_kind;
            odz_reg  <= res_dz;
        end
    end

    assign out_data      = {5'd0, odz_reg, ok_reg, ov_reg, oidx_reg};
    assign stat.action   = act_reg;
    assign stat.count    = cnt_reg;
    assign stat.div_done = (dcnt_reg == 6'd0);

endmodule

>>> hdl/fbe_ctrl.sv
// fbe_ctrl: sequencer for store clear, source reads, reduction, divide and result
// depends on fbe_pkg
module fbe_ctrl
    import fbe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_fire,
    output logic     in_ready,
    input  logic     out_taken,
    output logic     out_valid,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t            state_reg, state_next;
    logic [NODE_W:0]   cnt_reg, cnt_next;
    logic              busy_out_reg, busy_out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            busy_out_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            busy_out_reg <= busy_out_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        busy_out_next = busy_out_reg;
        cmd           = '0;
        cmd.clear_addr = cnt_reg[NODE_W-1:0];
        cmd.src_sel    = cnt_reg[SRC_W-1:0];
        in_ready      = 1'b0;
        if (busy_out_reg && out_taken)
            busy_out_next = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == (NODE_W+1)'(NODE_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_RDDST;
                end
            end
            ST_RDDST:
            begin
                cmd.rd_dst  = 1'b1;
                cmd.rd_src  = 1'b1;
                cmd.src_sel = '0;
                cnt_next    = '0;
                state_next  = ST_ACC;
            end
            ST_RDSRC:
            begin
                cmd.rd_src = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                // cnt holds the index of the source just read
                if (cnt_reg == '0)
                    cmd.acc_first = 1'b1;
                else
                    cmd.acc_step = 1'b1;
                if (action_t'(stat.action) == ACT_MUL && cnt_reg != '0)
                    state_next = ST_MULW;
                else
                    state_next = ST_WRITE;
                if (action_t'(stat.action) == ACT_SUB || action_t'(stat.action) == ACT_DIV)
                begin
                    if (cnt_reg == '0)
                    begin
                        cnt_next   = (NODE_W+1)'(1);
                        state_next = ST_RDSRC;
                    end
                    else if (action_t'(stat.action) == ACT_DIV)
                        state_next = ST_DIV;
                end
                else if (action_t'(stat.action) != ACT_MUL &&
                         (NODE_W+1)'(cnt_reg + 1) < (NODE_W+1)'(stat.count))
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_RDSRC;
                end
                if (action_t'(stat.action) == ACT_MUL && cnt_reg == '0 &&
                    (NODE_W+1)'(stat.count) > (NODE_W+1)'(1))
                begin
                    cnt_next   = (NODE_W+1)'(1);
                    state_next = ST_RDSRC;
                end
            end
            ST_MULW:
            begin
                cmd.mul_fin = 1'b1;
                if ((NODE_W+1)'(cnt_reg + 1) < (NODE_W+1)'(stat.count))
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_RDSRC;
                end
                else
                    state_next = ST_WRITE;
            end
            ST_DIV:
            begin
                if (cnt_reg == (NODE_W+1)'(1))
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = (NODE_W+1)'(2);
                end
                else if (stat.div_done)
                    state_next = ST_WRITE;
                else
                    cmd.div_step = 1'b1;
            end
            ST_WRITE:
            begin
                // result register must be free before it is overwritten
                if (!busy_out_reg || out_taken)
                begin
                    cmd.commit    = 1'b1;
                    busy_out_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = busy_out_reg;

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!busy_out_reg || out_taken))
        else $error("result overwritten before transfer");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> state_reg == ST_IDLE)
        else $error("item accepted while busy");
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("result not presented after commit");

endmodule

>>> hdl/function_block_evaluator_unit.sv
// function_block_evaluator_unit: top level of the function block evaluator
// depends on fbe_pkg, fbe_ctrl, fbe_datapath
//
// usage:
//   s_axis carries one block item (action, destination, count, eight source
//   indices, operand); m_axis returns the destination index, its new value,
//   kind and the divide-by-zero flag, one result per item.
//   the node store is one memory with one write and at most two reads per
//   cycle, so source values are read one at a time, each followed by an
//   accumulate step (a multiply step adds a wait state; sub and divide
//   always read two sources), and a divide then runs the one-bit-per-cycle
//   divider.
//   after reset the block clears all 256 nodes, one per cycle, with
//   s_axis_tready low while it clears.
//   the result sits in an output register; the next item is accepted while
//   it waits, but its own result is held back until the receiver has taken
//   the previous transfer, so a stalled receiver stops the block after one
//   item.
module function_block_evaluator_unit
    import fbe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[3:0], dest_node[11:4], source_count[15:12], source_0..7[79:16], operand[111:80]
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // node_index[7:0], node_value[39:8], value_kind[41:40], divide_by_zero[42]
    output logic [47:0]  m_axis_tdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    fbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_ready  (s_axis_tready),
        .out_taken (m_axis_tvalid && m_axis_tready),
        .out_valid (m_axis_tvalid),
        .stat      (stat),
        .cmd       (cmd)
    );

    fbe_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata)
    );

endmodule
